### design/mfde_pkg.sv
// Shared constants, codes and control types of the mono frame buffer draw engine.
package mfde_pkg;

   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int STORE_DEPTH   = 1024;
   localparam int ADDR_W        = 10;
   localparam int IDX_W         = 12;
   localparam int ERR_W         = 12;
   localparam int CIRC_W        = 12;

   // request command codes
   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_PIXEL  = 3'd1;
   localparam logic [2:0] CMD_LINE   = 3'd2;
   localparam logic [2:0] CMD_RECT   = 3'd3;
   localparam logic [2:0] CMD_FILL   = 3'd4;
   localparam logic [2:0] CMD_CIRCLE = 3'd5;
   localparam logic [2:0] CMD_READ   = 3'd6;

   // line segment select
   localparam logic [2:0] SEG_TOP    = 3'd0;
   localparam logic [2:0] SEG_BOTTOM = 3'd1;
   localparam logic [2:0] SEG_LEFT   = 3'd2;
   localparam logic [2:0] SEG_RIGHT  = 3'd3;
   localparam logic [2:0] SEG_FREE   = 3'd4;

   // pixel point source
   localparam logic [1:0] SRC_LINE = 2'd0;
   localparam logic [1:0] SRC_FILL = 2'd1;
   localparam logic [1:0] SRC_CIRC = 2'd2;

   typedef struct packed {
      logic       load;
      logic       clr_write;
      logic       fill_init;
      logic       fill_step;
      logic       line_init;
      logic [2:0] seg;
      logic       line_step;
      logic       circ_init;
      logic       circ_step;
      logic [1:0] src;
      logic [2:0] oct;
      logic       pix_read;
      logic       pix_write;
      logic       byte_read;
      logic       rsp_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic fill_empty;
      logic fill_last;
      logic line_done;
      logic circ_more;
   } dp_status_type;

endpackage

### design/mfde_datapath.sv
// Datapath: request registers, shape walkers, pixel read-modify-write and frame store.
module mfde_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  mfde_pkg::ctl_cmd_type cmd,
   output mfde_pkg::dp_status_type status,
   input  logic [2:0]            req_cmd,
   input  logic [7:0]            req_ax,
   input  logic [7:0]            req_ay,
   input  logic [7:0]            req_bx,
   input  logic [7:0]            req_by,
   input  logic [7:0]            req_radius,
   input  logic                  req_ink,
   input  logic [9:0]            req_read_addr,
   output logic [7:0]            rsp_read_data
);

   // request registers
   logic [2:0] cmd_ff;
   logic [7:0] ax_ff, ay_ff, bx_ff, by_ff, r_ff;
   logic       ink_ff;
   logic [mfde_pkg::ADDR_W-1:0] raddr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         ax_ff    <= req_ax;
         ay_ff    <= req_ay;
         bx_ff    <= req_bx;
         by_ff    <= req_by;
         r_ff     <= req_radius;
         ink_ff   <= req_ink;
         raddr_ff <= req_read_addr;
      end
   end

   logic [7:0] ex, ey;
   assign ex = ax_ff + bx_ff - 8'd1;
   assign ey = ay_ff + by_ff - 8'd1;

   // line walker
   logic [7:0] xa_ff, ya_ff, xb_ff, yb_ff, dx_ff, dy_ff;
   logic       sx_ff, sy_ff;
   logic signed [mfde_pkg::ERR_W-1:0] err_ff;
   logic [7:0] ixa, iya, ixb, iyb, idx_abs, idy_abs;
   logic signed [mfde_pkg::ERR_W:0] e2, dxs, dys;
   logic cond_x, cond_y;
   logic signed [mfde_pkg::ERR_W-1:0] err_in;

   // pick segment end points
   always_comb begin
      case (cmd.seg)
         mfde_pkg::SEG_TOP: begin
            ixa = ax_ff; iya = ay_ff; ixb = ex; iyb = ay_ff;
         end
         mfde_pkg::SEG_BOTTOM: begin
            ixa = ax_ff; iya = ey; ixb = ex; iyb = ey;
         end
         mfde_pkg::SEG_LEFT: begin
            ixa = ax_ff; iya = ay_ff; ixb = ax_ff; iyb = ey;
         end
         mfde_pkg::SEG_RIGHT: begin
            ixa = ex; iya = ay_ff; ixb = ex; iyb = ey;
         end
         default: begin
            ixa = ax_ff; iya = ay_ff; ixb = bx_ff; iyb = by_ff;
         end
      endcase
      idx_abs = (ixb > ixa) ? ixb - ixa : ixa - ixb;
      idy_abs = (iyb > iya) ? iyb - iya : iya - iyb;
   end

   // step decisions from the current error term
   always_comb begin
      e2     = {err_ff, 1'b0};
      dxs    = $signed({5'd0, dx_ff});
      dys    = $signed({5'd0, dy_ff});
      cond_x = (e2 >= -dys);
      cond_y = (e2 <= dxs);
      err_in = err_ff;
      if (cond_x) err_in = err_in - $signed({4'd0, dy_ff});
      if (cond_y) err_in = err_in + $signed({4'd0, dx_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.line_init) begin
         xa_ff  <= ixa;
         ya_ff  <= iya;
         xb_ff  <= ixb;
         yb_ff  <= iyb;
         dx_ff  <= idx_abs;
         dy_ff  <= idy_abs;
         sx_ff  <= (ixa < ixb);
         sy_ff  <= (iya < iyb);
         err_ff <= $signed({4'd0, idx_abs}) - $signed({4'd0, idy_abs});
      end else if (cmd.line_step) begin
         err_ff <= err_in;
         if (cond_x) xa_ff <= sx_ff ? xa_ff + 8'd1 : xa_ff - 8'd1;
         if (cond_y) ya_ff <= sy_ff ? ya_ff + 8'd1 : ya_ff - 8'd1;
      end
   end

   assign status.line_done = ((xa_ff == xb_ff) && (ya_ff == yb_ff)) ||
                             (cond_x && (xa_ff == xb_ff)) ||
                             (cond_y && (ya_ff == yb_ff));

   // circle walker
   logic [7:0] cx_ff, cy_ff;
   logic signed [mfde_pkg::CIRC_W-1:0] f_ff, ddx_ff, ddy_ff;
   logic signed [mfde_pkg::CIRC_W-1:0] f_a, ddy_n, ddx_n;

   always_comb begin
      ddx_n = ddx_ff + 12'sd2;
      ddy_n = ddy_ff;
      f_a   = f_ff;
      if (f_ff >= 0) begin
         ddy_n = ddy_ff + 12'sd2;
         f_a   = f_ff + ddy_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.circ_init) begin
         cx_ff  <= 8'd0;
         cy_ff  <= r_ff;
         f_ff   <= 12'sd1 - $signed({4'd0, r_ff});
         ddx_ff <= 12'sd1;
         ddy_ff <= -$signed({3'd0, r_ff, 1'b0});
      end else if (cmd.circ_step) begin
         if (f_ff >= 0) cy_ff <= cy_ff - 8'd1;
         cx_ff  <= cx_ff + 8'd1;
         ddx_ff <= ddx_n;
         ddy_ff <= ddy_n;
         f_ff   <= f_a + ddx_n;
      end
   end

   assign status.circ_more = (cx_ff < cy_ff);

   // fill walker
   logic [7:0] i_ff, j_ff;
   logic       j_last;
   assign j_last = (j_ff == by_ff - 8'd1);

   always_ff @(posedge clock) begin
      if (cmd.fill_init) begin
         i_ff <= 8'd0;
         j_ff <= 8'd0;
      end else if (cmd.fill_step) begin
         if (j_last) begin
            j_ff <= 8'd0;
            i_ff <= i_ff + 8'd1;
         end else begin
            j_ff <= j_ff + 8'd1;
         end
      end
   end

   assign status.fill_empty = (bx_ff == 8'd0) || (by_ff == 8'd0);
   assign status.fill_last  = (i_ff == bx_ff - 8'd1) && j_last;

   // select the point to plot
   logic [7:0] px, py;
   always_comb begin
      case (cmd.src)
         mfde_pkg::SRC_LINE: begin
            px = xa_ff; py = ya_ff;
         end
         mfde_pkg::SRC_CIRC: begin
            case (cmd.oct)
               3'd0: begin px = ax_ff + cx_ff; py = ay_ff + cy_ff; end
               3'd1: begin px = ax_ff - cx_ff; py = ay_ff + cy_ff; end
               3'd2: begin px = ax_ff + cx_ff; py = ay_ff - cy_ff; end
               3'd3: begin px = ax_ff - cx_ff; py = ay_ff - cy_ff; end
               3'd4: begin px = ax_ff + cy_ff; py = ay_ff + cx_ff; end
               3'd5: begin px = ax_ff - cy_ff; py = ay_ff + cx_ff; end
               3'd6: begin px = ax_ff + cy_ff; py = ay_ff - cx_ff; end
               default: begin px = ax_ff - cy_ff; py = ay_ff - cx_ff; end
            endcase
         end
         default: begin
            px = ax_ff + i_ff; py = ay_ff + j_ff;
         end
      endcase
   end

   // map point to store byte
   logic [mfde_pkg::IDX_W-1:0] pidx;
   logic                       pok;
   assign pidx = mfde_pkg::IDX_W'(px) +
                 mfde_pkg::IDX_W'(32'(py >> 3) * mfde_pkg::SCREEN_WIDTH);
   assign pok  = (32'(px) < mfde_pkg::SCREEN_WIDTH) &&
                 (32'(py) < mfde_pkg::SCREEN_HEIGHT) &&
                 (32'(pidx) < mfde_pkg::STORE_DEPTH);

   logic [mfde_pkg::ADDR_W-1:0] paddr_ff;
   logic [2:0]                  pbit_ff;
   logic                        pok_ff;
   always_ff @(posedge clock) begin
      if (cmd.pix_read) begin
         paddr_ff <= pidx[mfde_pkg::ADDR_W-1:0];
         pbit_ff  <= py[2:0];
         pok_ff   <= pok;
      end
   end

   // clearing sweep counter
   logic [mfde_pkg::ADDR_W-1:0] clr_ff;
   assign status.clr_last = (clr_ff == mfde_pkg::ADDR_W'(mfde_pkg::STORE_DEPTH - 1));
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= status.clr_last ? '0 : clr_ff + mfde_pkg::ADDR_W'(1);
      end
   end

   // frame store
   logic [7:0] mem [mfde_pkg::STORE_DEPTH];
   logic [7:0] mem_rd_ff;
   logic [7:0] mask, wdata;
   logic [mfde_pkg::ADDR_W-1:0] waddr, raddr;
   logic we, re;

   always_comb begin
      mask  = 8'd1 << pbit_ff;
      we    = cmd.clr_write | (cmd.pix_write & pok_ff);
      waddr = cmd.clr_write ? clr_ff : paddr_ff;
      if (cmd.clr_write) wdata = 8'd0;
      else if (ink_ff) wdata = mem_rd_ff | mask;
      else wdata = mem_rd_ff & ~mask;
      re    = cmd.pix_read | cmd.byte_read;
      raddr = cmd.pix_read ? pidx[mfde_pkg::ADDR_W-1:0] : raddr_ff;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) mem_rd_ff <= mem[raddr];
   end

   // result register
   logic [7:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= (cmd_ff == mfde_pkg::CMD_READ) ? mem_rd_ff : 8'd0;
      end
   end
   assign rsp_read_data = rsp_data_ff;

endmodule

### design/mfde_controller.sv
// Controller: sequences clearing, pixel, line, rectangle, fill, circle and read requests.
module mfde_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mfde_pkg::ctl_cmd_type   cmd,
   input  mfde_pkg::dp_status_type status
);

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_PIX_RD    = 4'd2;
   localparam logic [3:0] S_PIX_WR    = 4'd3;
   localparam logic [3:0] S_FILL_CHK  = 4'd4;
   localparam logic [3:0] S_FILL_RD   = 4'd5;
   localparam logic [3:0] S_FILL_WR   = 4'd6;
   localparam logic [3:0] S_LINE_INIT = 4'd7;
   localparam logic [3:0] S_LINE_RD   = 4'd8;
   localparam logic [3:0] S_LINE_WR   = 4'd9;
   localparam logic [3:0] S_CIRC_INIT = 4'd10;
   localparam logic [3:0] S_CIRC_RD   = 4'd11;
   localparam logic [3:0] S_CIRC_WR   = 4'd12;
   localparam logic [3:0] S_CIRC_STEP = 4'd13;
   localparam logic [3:0] S_BYTE_RD   = 4'd14;
   localparam logic [3:0] S_RSP       = 4'd15;

   logic [3:0] state_ff, state_in;
   logic [2:0] seg_ff, seg_in;
   logic [2:0] oct_ff, oct_in;
   logic       boot_ff, boot_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      oct_in   = oct_ff;
      boot_in  = boot_ff;
      cmd      = '0;
      cmd.seg  = seg_ff;
      cmd.oct  = oct_ff;
      cmd.src  = mfde_pkg::SRC_FILL;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_RSP;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_cmd)
                  mfde_pkg::CMD_CLEAR: state_in = S_CLEAR;
                  mfde_pkg::CMD_PIXEL: begin
                     cmd.fill_init = 1'b1;
                     state_in      = S_PIX_RD;
                  end
                  mfde_pkg::CMD_LINE: begin
                     seg_in   = mfde_pkg::SEG_FREE;
                     state_in = S_LINE_INIT;
                  end
                  mfde_pkg::CMD_RECT: begin
                     seg_in   = mfde_pkg::SEG_TOP;
                     state_in = S_LINE_INIT;
                  end
                  mfde_pkg::CMD_FILL: begin
                     cmd.fill_init = 1'b1;
                     state_in      = S_FILL_CHK;
                  end
                  mfde_pkg::CMD_CIRCLE: state_in = S_CIRC_INIT;
                  mfde_pkg::CMD_READ:   state_in = S_BYTE_RD;
                  default:              state_in = S_RSP;
               endcase
            end
         end
         S_PIX_RD: begin
            cmd.pix_read = 1'b1;
            state_in     = S_PIX_WR;
         end
         S_PIX_WR: begin
            cmd.pix_write = 1'b1;
            state_in      = S_RSP;
         end
         S_FILL_CHK: begin
            state_in = status.fill_empty ? S_RSP : S_FILL_RD;
         end
         S_FILL_RD: begin
            cmd.pix_read = 1'b1;
            state_in     = S_FILL_WR;
         end
         S_FILL_WR: begin
            cmd.pix_write = 1'b1;
            if (status.fill_last) begin
               state_in = S_RSP;
            end else begin
               cmd.fill_step = 1'b1;
               state_in      = S_FILL_RD;
            end
         end
         S_LINE_INIT: begin
            cmd.line_init = 1'b1;
            state_in      = S_LINE_RD;
         end
         S_LINE_RD: begin
            cmd.src      = mfde_pkg::SRC_LINE;
            cmd.pix_read = 1'b1;
            state_in     = S_LINE_WR;
         end
         S_LINE_WR: begin
            cmd.src       = mfde_pkg::SRC_LINE;
            cmd.pix_write = 1'b1;
            if (status.line_done) begin
               // advance to the next rectangle side or finish
               if (seg_ff == mfde_pkg::SEG_FREE || seg_ff == mfde_pkg::SEG_RIGHT) begin
                  state_in = S_RSP;
               end else begin
                  seg_in   = seg_ff + 3'd1;
                  state_in = S_LINE_INIT;
               end
            end else begin
               cmd.line_step = 1'b1;
               state_in      = S_LINE_RD;
            end
         end
         S_CIRC_INIT: begin
            cmd.circ_init = 1'b1;
            oct_in        = 3'd0;
            state_in      = S_CIRC_RD;
         end
         S_CIRC_RD: begin
            cmd.src      = mfde_pkg::SRC_CIRC;
            cmd.pix_read = 1'b1;
            state_in     = S_CIRC_WR;
         end
         S_CIRC_WR: begin
            cmd.src       = mfde_pkg::SRC_CIRC;
            cmd.pix_write = 1'b1;
            oct_in        = oct_ff + 3'd1;
            if (oct_ff == 3'd7) begin
               state_in = status.circ_more ? S_CIRC_STEP : S_RSP;
            end else begin
               state_in = S_CIRC_RD;
            end
         end
         S_CIRC_STEP: begin
            cmd.circ_step = 1'b1;
            state_in      = S_CIRC_RD;
         end
         S_BYTE_RD: begin
            cmd.byte_read = 1'b1;
            state_in      = S_RSP;
         end
         S_RSP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         seg_ff       <= mfde_pkg::SEG_TOP;
         oct_ff       <= 3'd0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         oct_ff       <= oct_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### design/mono_framebuffer_draw_engine.sv
// Top level of the mono frame buffer draw engine.
// One-bit-per-pixel drawing engine over a 1024-byte page-organized frame store
// (byte = x + (y/8)*width, bit = y%8). After reset the engine sweeps the store to
// zero, one byte a cycle, before it takes its first request. Each request returns
// one response: the stored byte for a read, zero otherwise. Every plotted pixel is a
// read-modify-write of the frame store: a read state, then a write state. One
// request is worked at a time; a new one is taken while the previous response
// waits.
module mono_framebuffer_draw_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_ax,
   input  logic [7:0] req_ay,
   input  logic [7:0] req_bx,
   input  logic [7:0] req_by,
   input  logic [7:0] req_radius,
   input  logic       req_ink,
   input  logic [9:0] req_read_addr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data
);

   mfde_pkg::ctl_cmd_type   cmd;
   mfde_pkg::dp_status_type status;

   mfde_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mfde_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_cmd       (req_cmd),
      .req_ax        (req_ax),
      .req_ay        (req_ay),
      .req_bx        (req_bx),
      .req_by        (req_by),
      .req_radius    (req_radius),
      .req_ink       (req_ink),
      .req_read_addr (req_read_addr),
      .rsp_read_data (rsp_read_data)
   );

endmodule

### bench/tb.sv
// Self-checking testbench of the mono frame buffer draw engine.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_cmd;
   logic [7:0] req_ax, req_ay, req_bx, req_by, req_radius;
   logic       req_ink;
   logic [9:0] req_read_addr;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_read_data;

   mono_framebuffer_draw_engine dut (.*);

   typedef struct {
      logic [2:0] cmd;
      logic [7:0] ax, ay, bx, by, radius;
      logic       ink;
      logic [9:0] addr;
   } draw_req_type;

   // directed row: request plus an optional typed-in expected byte
   typedef struct {
      draw_req_type r;
      bit           fixed;
      logic [7:0]   data;
   } dir_row_type;

   // mirror of the engine state
   logic [7:0]  pix_mem [mfde_pkg::STORE_DEPTH];
   logic [15:0] line_err;
   logic [7:0]  end_x, end_y;

   logic [7:0] exp_bytes[$];
   int         mismatches;
   int         rsp_count;
   bit         failed;
   bit         hold_off;
   bit         no_idle;

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #200ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void put_pixel(int x, int y, logic ink);
      int px, py, idx;
      px = x & 8'hff;
      py = y & 8'hff;
      if (px >= mfde_pkg::SCREEN_WIDTH || py >= mfde_pkg::SCREEN_HEIGHT) return;
      idx = px + (py / 8) * mfde_pkg::SCREEN_WIDTH;
      if (idx >= mfde_pkg::STORE_DEPTH) return;
      pix_mem[idx][py % 8] = ink;
   endfunction

   function automatic void draw_line(int x0, int y0, int x1, int y1, logic ink);
      int xa, ya, xb, yb, dx, dy, sx, sy, err, e2;
      xa = x0 & 8'hff; ya = y0 & 8'hff; xb = x1 & 8'hff; yb = y1 & 8'hff;
      dx = xb > xa ? xb - xa : xa - xb;
      dy = -(yb > ya ? yb - ya : ya - yb);
      sx = xa < xb ? 1 : -1;
      sy = ya < yb ? 1 : -1;
      err = dx + dy;
      forever begin
         put_pixel(xa, ya, ink);
         if (xa == xb && ya == yb) break;
         e2 = 2 * err;
         if (e2 >= dy) begin
            if (xa == xb) break;
            err += dy;
            xa += sx;
         end
         if (e2 <= dx) begin
            if (ya == yb) break;
            err += dx;
            ya += sy;
         end
      end
      end_x = xa[7:0];
      end_y = ya[7:0];
      line_err = err[15:0];
   endfunction

   function automatic void draw_circle(int cx, int cy, int r, logic ink);
      int f, ddx, ddy, x, y;
      f = 1 - r; ddx = 1; ddy = -2 * r; x = 0; y = r;
      put_pixel(cx, cy + r, ink);
      put_pixel(cx, cy - r, ink);
      put_pixel(cx + r, cy, ink);
      put_pixel(cx - r, cy, ink);
      while (x < y) begin
         if (f >= 0) begin
            y--;
            ddy += 2;
            f += ddy;
         end
         x++;
         ddx += 2;
         f += ddx;
         put_pixel(cx + x, cy + y, ink);
         put_pixel(cx - x, cy + y, ink);
         put_pixel(cx + x, cy - y, ink);
         put_pixel(cx - x, cy - y, ink);
         put_pixel(cx + y, cy + x, ink);
         put_pixel(cx - y, cy + x, ink);
         put_pixel(cx + y, cy - x, ink);
         put_pixel(cx - y, cy - x, ink);
      end
   endfunction

   // apply one request to the mirror and return the byte it answers with
   function automatic logic [7:0] render_request(draw_req_type q);
      int ex, ey;
      logic [7:0] data;
      data = 8'h00;
      ex = (q.ax + q.bx - 1) & 8'hff;
      ey = (q.ay + q.by - 1) & 8'hff;
      case (q.cmd)
         mfde_pkg::CMD_CLEAR: begin
            foreach (pix_mem[i]) pix_mem[i] = 8'h00;
         end
         mfde_pkg::CMD_PIXEL: put_pixel(q.ax, q.ay, q.ink);
         mfde_pkg::CMD_LINE: draw_line(q.ax, q.ay, q.bx, q.by, q.ink);
         mfde_pkg::CMD_RECT: begin
            draw_line(q.ax, q.ay, ex, q.ay, q.ink);
            draw_line(q.ax, ey, ex, ey, q.ink);
            draw_line(q.ax, q.ay, q.ax, ey, q.ink);
            draw_line(ex, q.ay, ex, ey, q.ink);
         end
         mfde_pkg::CMD_FILL: begin
            for (int i = 0; i < q.bx; i++)
               for (int j = 0; j < q.by; j++)
                  put_pixel(q.ax + i, q.ay + j, q.ink);
         end
         mfde_pkg::CMD_CIRCLE: draw_circle(q.ax, q.ay, q.radius, q.ink);
         mfde_pkg::CMD_READ: data = pix_mem[q.addr];
         default: ;
      endcase
      return data;
   endfunction

   function automatic draw_req_type mk(logic [2:0] c, logic [7:0] ax, logic [7:0] ay,
                                       logic [7:0] bx, logic [7:0] by, logic [7:0] r,
                                       logic ink, logic [9:0] a);
      draw_req_type q;
      q.cmd = c; q.ax = ax; q.ay = ay; q.bx = bx; q.by = by;
      q.radius = r; q.ink = ink; q.addr = a;
      return q;
   endfunction

   // random request: coordinates mostly small and near the screen, few large ones
   function automatic draw_req_type rand_request();
      draw_req_type q;
      int k;
      q.ax = $urandom; q.ay = $urandom; q.bx = $urandom; q.by = $urandom;
      q.radius = $urandom; q.ink = $urandom; q.addr = $urandom;
      k = $urandom_range(0, 99);
      if (k < 2) q.cmd = mfde_pkg::CMD_CLEAR;
      else if (k < 20) q.cmd = mfde_pkg::CMD_PIXEL;
      else if (k < 32) q.cmd = mfde_pkg::CMD_LINE;
      else if (k < 40) q.cmd = mfde_pkg::CMD_RECT;
      else if (k < 48) q.cmd = mfde_pkg::CMD_FILL;
      else if (k < 56) q.cmd = mfde_pkg::CMD_CIRCLE;
      else if (k < 98) q.cmd = mfde_pkg::CMD_READ;
      else q.cmd = 3'd7;
      if ($urandom_range(0, 9) < 8) begin
         q.ax = $urandom_range(0, 140);
         q.ay = $urandom_range(0, 70);
         if (q.cmd inside {mfde_pkg::CMD_RECT, mfde_pkg::CMD_FILL}) begin
            q.bx = $urandom_range(0, 12);
            q.by = $urandom_range(0, 12);
         end
         if (q.cmd == mfde_pkg::CMD_LINE) begin
            q.bx = q.ax + $urandom_range(0, 40) - 20;
            q.by = q.ay + $urandom_range(0, 40) - 20;
         end
         q.radius = $urandom_range(0, 20);
      end
      if (q.cmd == mfde_pkg::CMD_READ && $urandom_range(0, 3) != 0)
         q.addr = $urandom_range(0, 1023) & 10'h3ff;
      return q;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_request(draw_req_type q, bit fixed, logic [7:0] data);
      while (!no_idle && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= q.cmd;
      req_ax        <= q.ax;
      req_ay        <= q.ay;
      req_bx        <= q.bx;
      req_by        <= q.by;
      req_radius    <= q.radius;
      req_ink       <= q.ink;
      req_read_addr <= q.addr;
      do @(posedge clock); while (req_stall);
      begin
         logic [7:0] pred;
         pred = render_request(q);
         if (fixed && pred != data) begin
            $display("table row disagrees: cmd %0d typed %h mirror %h", q.cmd, data, pred);
            failed = 1;
         end
         exp_bytes.push_back(fixed ? data : pred);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (exp_bytes.size() != 0) @(posedge clock);
   endtask

   // response side: stall at random, or hold off on request
   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else if (hold_off)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 21);
   end

   // check each response against the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (exp_bytes.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("response with none expected: %h", rsp_read_data);
         end else begin
            logic [7:0] want;
            want = exp_bytes.pop_front();
            if (rsp_read_data !== want) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("read_data mismatch: expected %h got %h", want, rsp_read_data);
            end
         end
      end
   end

   // long receiver hold-off, counted in cycles
   task automatic hold_responses(int cycles);
      hold_off = 1;
      repeat (cycles) @(posedge clock);
      hold_off = 0;
   endtask

   dir_row_type rows[$];

   initial begin
      foreach (pix_mem[i]) pix_mem[i] = 8'h00;
      line_err = 0; end_x = 0; end_y = 0;
      mismatches = 0; rsp_count = 0; failed = 0; hold_off = 0; no_idle = 0;
      reset = 1; req_valid = 0; req_cmd = mfde_pkg::CMD_CLEAR; req_ax = 0; req_ay = 0;
      req_bx = 0; req_by = 0; req_radius = 0; req_ink = 0; req_read_addr = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 255, 255, 255, 255, 255, 1, 10'd1023),
                       1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd0), 1, 8'h01});
      rows.push_back('{mk(mfde_pkg::CMD_PIXEL, 127, 63, 0, 0, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd1023), 1, 8'h80});
      rows.push_back('{mk(mfde_pkg::CMD_PIXEL, 128, 10, 0, 0, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_PIXEL, 5, 64, 0, 0, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_PIXEL, 255, 255, 0, 0, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_LINE, 0, 0, 127, 63, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_LINE, 250, 70, 3, 2, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_RECT, 10, 10, 20, 12, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_RECT, 100, 40, 0, 0, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_FILL, 30, 20, 0, 5, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_FILL, 120, 60, 16, 9, 0, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_CIRCLE, 64, 32, 0, 0, 20, 1, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_CIRCLE, 2, 2, 0, 0, 255, 0, 0), 1, 8'h00});
      rows.push_back('{mk(3'd7, 1, 1, 1, 1, 1, 1, 10'd5), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd148), 0, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd1016), 0, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00});
      rows.push_back('{mk(mfde_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 10'd148), 1, 8'h00});
      foreach (rows[i]) send_request(rows[i].r, rows[i].fixed, rows[i].data);

      // sender pauses until every expected response has come
      drain();

      // receiver holds off while the sender keeps offering
      fork
         hold_responses(3000);
         begin
            for (int i = 0; i < 6; i++) send_request(rand_request(), 0, 0);
            req_valid <= 1'b0;
         end
      join

      for (int i = 0; i < 830; i++) begin
         no_idle = (i >= 300 && i < 420);
         send_request(rand_request(), 0, 0);
      end
      no_idle = 0;
      drain();
      repeat (2000) @(posedge clock);

      if (!failed && exp_bytes.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
